// File: rtl/acc8_pkg.sv
package acc8_pkg;

  localparam int REG_COUNT = 16;

  typedef enum logic [1:0] {
    FN_EXEC    = 2'd0,
    FN_PRELOAD = 2'd1,
    FN_MEM_RD  = 2'd2,
    FN_REG_RD  = 2'd3
  } func_t;

  // Low nibble of the opcode when instruction bit 8 is clear.
  typedef enum logic [3:0] {
    OP_MOV_TO_ACC   = 4'd0,
    OP_LOAD         = 4'd1,
    OP_ADD          = 4'd2,
    OP_BEZ          = 4'd3,
    OP_BNEZ         = 4'd4,
    OP_SLC          = 4'd5,
    OP_SHL          = 4'd6,
    OP_INC          = 4'd7,
    OP_SHR          = 4'd8,
    OP_MOV_FROM_ACC = 4'd9,
    OP_SUB          = 4'd10,
    OP_NOT          = 4'd11,
    OP_AND          = 4'd12,
    OP_XOR          = 4'd13,
    OP_STORE        = 4'd14,
    OP_HALT         = 4'd15
  } op_t;

  localparam logic [7:0] BEZ_BIAS  = 8'd2;
  localparam logic [7:0] BNEZ_BIAS = 8'd4;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       halted;
    logic       carry;
    logic       branch_taken;
    logic       reg_we;
    logic [3:0] reg_idx;
    logic [7:0] reg_value;
    logic       reg_from_mem;
    logic       mem_we;
    logic [7:0] mem_addr;
    logic [7:0] mem_value;
    logic       mem_re;
    logic [7:0] mem_raddr;
    logic [7:0] read_data;
    logic       read_from_mem;
  } exec_t;

endpackage

// File: rtl/acc8_ram.sv
module acc8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/acc8_exec.sv
module acc8_exec (
  input  logic [1:0]      func,
  input  logic [8:0]      instruction,
  input  logic [7:0]      address,
  input  logic [7:0]      data,
  input  logic [7:0]      pc,
  input  logic            halt,
  input  logic            carry,
  input  logic [7:0]      acc,
  input  logic [7:0]      opnd,
  output acc8_pkg::exec_t res
);

  import acc8_pkg::*;

  func_t      fn;
  op_t        op;
  logic [3:0] r;
  logic [7:0] sx;
  logic [7:0] bias;
  logic [7:0] offs;
  logic       cond;

  always_comb begin
    fn   = func_t'(func);
    op   = op_t'(instruction[7:4]);
    r    = instruction[3:0];
    sx   = {{4{r[3]}}, r};
    bias = (op == OP_BEZ) ? BEZ_BIAS : BNEZ_BIAS;
    offs = {sx[6:0], 1'b0} - bias;
    cond = (op == OP_BEZ) ? (acc == 8'd0) : (acc != 8'd0);

    res         = '0;
    res.next_pc = pc;
    res.halted  = halt;
    res.carry   = carry;

    case (fn)
      FN_PRELOAD: begin
        res.mem_we    = 1'b1;
        res.mem_addr  = address;
        res.mem_value = data;
      end
      FN_MEM_RD: begin
        res.mem_re        = 1'b1;
        res.mem_raddr     = address;
        res.read_from_mem = 1'b1;
      end
      FN_REG_RD: begin
        res.read_data = opnd;
      end
      FN_EXEC: begin
        // A halted core ignores the word and reports its frozen state.
        if (!halt) begin
          res.next_pc = pc + 8'd1;
          if (instruction[8]) begin
            res.reg_we    = 1'b1;
            res.reg_value = instruction[7:0];
          end else begin
            case (op)
              OP_MOV_TO_ACC: begin
                res.reg_we    = 1'b1;
                res.reg_value = opnd;
              end
              OP_LOAD: begin
                res.reg_we       = 1'b1;
                res.reg_idx      = r;
                res.reg_from_mem = 1'b1;
                res.mem_re       = 1'b1;
                res.mem_raddr    = acc;
              end
              OP_ADD: begin
                res.reg_we    = 1'b1;
                res.reg_value = acc + opnd;
              end
              OP_BEZ, OP_BNEZ: begin
                if (cond) begin
                  res.branch_taken = 1'b1;
                  res.next_pc      = pc + offs;
                end
              end
              OP_SLC: begin
                res.reg_we    = 1'b1;
                res.reg_idx   = r;
                res.reg_value = {opnd[6:0], carry};
                res.carry     = opnd[7];
              end
              OP_SHL: begin
                res.reg_we    = 1'b1;
                res.reg_idx   = r;
                res.reg_value = {opnd[6:0], 1'b0};
                res.carry     = opnd[7];
              end
              OP_INC: begin
                res.reg_we    = 1'b1;
                res.reg_idx   = r;
                res.reg_value = opnd + 8'd1;
              end
              OP_SHR: begin
                res.reg_we    = 1'b1;
                res.reg_idx   = r;
                res.reg_value = {1'b0, opnd[7:1]};
              end
              OP_MOV_FROM_ACC: begin
                res.reg_we    = 1'b1;
                res.reg_idx   = r;
                res.reg_value = acc;
              end
              OP_SUB: begin
                res.reg_we    = 1'b1;
                res.reg_value = acc - opnd;
              end
              OP_NOT: begin
                res.reg_we    = 1'b1;
                res.reg_idx   = r;
                res.reg_value = ~opnd;
              end
              OP_AND: begin
                res.reg_we    = 1'b1;
                res.reg_value = acc & opnd;
              end
              OP_XOR: begin
                res.reg_we    = 1'b1;
                res.reg_value = acc ^ opnd;
              end
              OP_STORE: begin
                res.mem_we    = 1'b1;
                res.mem_addr  = acc;
                res.mem_value = opnd;
              end
              OP_HALT: begin
                res.halted  = 1'b1;
                res.next_pc = pc;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/accumulator_core_8bit.sv
// 8-bit accumulator core: one input word per clock, unless the input stalls, either
// executes an instruction or performs a debug preload or read, and one output word
// reports the resulting pc, flags, register or memory write and read data. Each
// word passes through the first stage register and the output register, because
// the data memory read is registered. A load writes its register in the following
// cycle and is forwarded to a word taken in that cycle. Addresses wrap modulo
// DATA_MEM_DEPTH; a data memory entry read before it is written returns garbage.
module accumulator_core_8bit #(
  parameter int DATA_MEM_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [8:0] in_instruction,
  input  logic [7:0] in_address,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_next_pc,
  output logic       out_halted,
  output logic       out_branch_taken,
  output logic       out_reg_write_en,
  output logic [3:0] out_reg_index,
  output logic [7:0] out_reg_value,
  output logic       out_mem_write_en,
  output logic [7:0] out_mem_address,
  output logic [7:0] out_mem_value,
  output logic       out_carry,
  output logic [7:0] out_read_data
);

  import acc8_pkg::*;

  localparam int AW = (DATA_MEM_DEPTH > 1) ? $clog2(DATA_MEM_DEPTH) : 1;

  // Reduce an 8-bit address modulo the depth; the user must keep the depth at least 16
  // (the block does not enforce this), so the quotient fits in four restoring steps.
  function automatic logic [AW-1:0] mem_idx(input logic [7:0] a);
    logic [11:0] t;
    t = {4'd0, a};
    for (int k = 3; k >= 0; k--) begin
      if (t >= (12'(DATA_MEM_DEPTH) << k)) begin
        t = t - (12'(DATA_MEM_DEPTH) << k);
      end
    end
    return t[AW-1:0];
  endfunction

  logic [7:0] rf_r [REG_COUNT];
  logic [7:0] pc_r;
  logic       halt_r;
  logic       carry_r;
  logic       wb_pend_r;
  logic       s1_valid_r;
  exec_t      s1_r;
  logic       out_valid_r;
  exec_t      out_r;

  exec_t      ex;
  exec_t      s1_fix;
  logic [3:0] sel;
  logic [7:0] opnd;
  logic [7:0] acc;
  logic [7:0] ram_rdata;
  logic       acc_fire;
  logic       s1_adv;
  logic       wb_override;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign acc_fire = in_valid && !in_stall;

  // A younger write to the same register takes priority over the load.
  assign wb_override = acc_fire && ex.reg_we && !ex.reg_from_mem &&
                       (ex.reg_idx == s1_r.reg_idx);

  // A load issued last cycle has its data on the RAM output; forward it.
  always_comb begin
    sel  = (in_func == FN_REG_RD) ? in_address[3:0] : in_instruction[3:0];
    opnd = (wb_pend_r && s1_r.reg_idx == sel) ? ram_rdata : rf_r[sel];
    acc  = (wb_pend_r && s1_r.reg_idx == 4'd0) ? ram_rdata : rf_r[0];
  end

  acc8_exec u_exec (
    .func        (in_func),
    .instruction (in_instruction),
    .address     (in_address),
    .data        (in_data),
    .pc          (pc_r),
    .halt        (halt_r),
    .carry       (carry_r),
    .acc         (acc),
    .opnd        (opnd),
    .res         (ex)
  );

  acc8_ram #(
    .WIDTH (8),
    .DEPTH (DATA_MEM_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .we    (acc_fire && ex.mem_we),
    .waddr (mem_idx(ex.mem_addr)),
    .wdata (ex.mem_value),
    .re    (acc_fire && ex.mem_re),
    .raddr (mem_idx(ex.mem_raddr)),
    .rdata (ram_rdata)
  );

  // The RAM output holds while the first stage waits, since no new read
  // can start until it moves on.
  always_comb begin
    s1_fix = s1_r;
    if (s1_r.reg_from_mem) begin
      s1_fix.reg_value = ram_rdata;
    end
    if (s1_r.read_from_mem) begin
      s1_fix.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halt_r      <= 1'b0;
      carry_r     <= 1'b0;
      wb_pend_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      wb_pend_r <= acc_fire && ex.reg_from_mem;
      if (wb_pend_r && !wb_override) begin
        rf_r[s1_r.reg_idx] <= ram_rdata;
      end
      if (acc_fire) begin
        pc_r    <= ex.next_pc;
        halt_r  <= ex.halted;
        carry_r <= ex.carry;
        if (ex.reg_we && !ex.reg_from_mem) begin
          rf_r[ex.reg_idx] <= ex.reg_value;
        end
      end
      if (acc_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      s1_r <= ex;
    end
    if (s1_adv) begin
      out_r <= s1_fix;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_r.next_pc;
  assign out_halted       = out_r.halted;
  assign out_branch_taken = out_r.branch_taken;
  assign out_reg_write_en = out_r.reg_we;
  assign out_reg_index    = out_r.reg_idx;
  assign out_reg_value    = out_r.reg_value;
  assign out_mem_write_en = out_r.mem_we;
  assign out_mem_address  = out_r.mem_addr;
  assign out_mem_value    = out_r.mem_value;
  assign out_carry        = out_r.carry;
  assign out_read_data    = out_r.read_data;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty first stage");

  a_wb_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    wb_pend_r |-> s1_valid_r)
    else $error("load writeback pending without its word in the first stage");

  a_halt_freezes_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_fire && halt_r && in_func == FN_EXEC) |=> pc_r == $past(pc_r))
    else $error("pc moved while halted");

  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ex.mem_we && ex.mem_re))
    else $error("one word both reads and writes data memory");

endmodule
